// ----- hdl/praru_pkg.sv -----
// ----------------------------------------------------------------------------
// praru_pkg
// Shared constants, codes and types of the round-robin admission unit.
// ----------------------------------------------------------------------------
package praru_pkg;

    // default sizing for the top-level parameters
    localparam int MAX_CONNS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    // priority classes; a power of two, so the class is the low hash bits
    localparam int NUM_PRIO = 128;
    localparam int PRIO_W   = $clog2(NUM_PRIO);

    // field widths of the channels
    localparam int TYPE_W     = 2;
    localparam int HASH_W     = 31;
    localparam int CONN_IDX_W = 3;
    localparam int LEVEL_W    = 8;
    localparam int ID_W       = 32;
    localparam int OUT_PRIO_W = 7;
    localparam int DRAIN_W    = 5;
    localparam int DROP_W     = 32;
    localparam int SENT_W     = 32;

    // configuration registers
    localparam int NUM_CONNS_W = 4;
    localparam int INIT_PRIO_W = 7;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0]   CFG_NUM_CONNS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0]   CFG_INITIAL_PRIO = CFG_IDX_W'(1);

    localparam logic [NUM_CONNS_W-1:0] NUM_CONNS_RESET  = NUM_CONNS_W'(1);
    localparam logic [LEVEL_W-1:0]     LEVEL_RESET      = LEVEL_W'(127);
    localparam logic [ID_W-1:0]        ID_RESET         = ID_W'(1);

    // depth of the command queue between front and back
    localparam int CMD_QUEUE_DEPTH = 2;

    // request type codes on the input channel
    typedef enum logic [TYPE_W-1:0] {
        REQ_SEND   = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_DRAIN  = 2'd2
    } req_type_t;

    // classified operation handed to the back end
    typedef enum logic [1:0] {
        OP_SEND,
        OP_UPDATE,
        OP_DRAIN,
        OP_IGNORE
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [PRIO_W-1:0]     prio;
        logic [CONN_IDX_W-1:0] conn;
        logic                  conn_ok;
        logic [LEVEL_W-1:0]    level;
    } cmd_t;

    typedef struct packed {
        logic [NUM_CONNS_W-1:0] num_conns;
        logic                   load_prio;
        logic [INIT_PRIO_W-1:0] load_level;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ----- hdl/praru_if.sv -----
// ----------------------------------------------------------------------------
// praru_if
// Valid/ready channels of the admission unit: request in, result out.
// ----------------------------------------------------------------------------
interface praru_req_if;
    import praru_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [TYPE_W-1:0]     req_type;
    logic [HASH_W-1:0]     hash;
    logic [CONN_IDX_W-1:0] conn_index;
    logic [LEVEL_W-1:0]    new_prio;

    modport source (output valid, req_type, hash, conn_index, new_prio, input ready);
    modport sink   (input valid, req_type, hash, conn_index, new_prio, output ready);
endinterface

interface praru_rsp_if;
    import praru_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  accepted;
    logic [CONN_IDX_W-1:0] chosen_conn;
    logic [ID_W-1:0]       request_id;
    logic [OUT_PRIO_W-1:0] request_prio;
    logic [DRAIN_W-1:0]    drained_count;
    logic [DROP_W-1:0]     drop_total;

    modport source (output valid, accepted, chosen_conn, request_id, request_prio,
                    drained_count, drop_total, input ready);
    modport sink   (input valid, accepted, chosen_conn, request_id, request_prio,
                    drained_count, drop_total, output ready);
endinterface

// ----- hdl/praru_front.sv -----
// ----------------------------------------------------------------------------
// praru_front
// Takes request transactions, decodes and checks them, and holds one
// classified command until the command queue takes it.
// ----------------------------------------------------------------------------
module praru_front #(
    parameter int MAX_CONNS = praru_pkg::MAX_CONNS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    praru_req_if.sink        req,
    output praru_pkg::cmd_t  cmd,
    output logic             push,
    input  praru_pkg::qstat_t qstat
);
    import praru_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic take;

    assign push      = valid_reg && !qstat.full;
    assign req.ready = !valid_reg || !qstat.full;
    assign take      = req.valid && req.ready;
    assign cmd       = cmd_reg;

    // classify the incoming transaction
    always_comb
    begin
        cmd_next.prio    = req.hash[PRIO_W-1:0];
        cmd_next.conn    = req.conn_index;
        cmd_next.conn_ok = (32'(req.conn_index) < 32'(MAX_CONNS));
        cmd_next.level   = req.new_prio;
        case (req_type_t'(req.req_type))
            REQ_SEND:   cmd_next.op = OP_SEND;
            REQ_UPDATE: cmd_next.op = OP_UPDATE;
            REQ_DRAIN:  cmd_next.op = OP_DRAIN;
            default:    cmd_next.op = OP_IGNORE;
        endcase
    end

    // holding stage occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ----- hdl/praru_fifo.sv -----
// ----------------------------------------------------------------------------
// praru_fifo
// Small register queue of commands between the front and back ends.
// ----------------------------------------------------------------------------
module praru_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = praru_pkg::CMD_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [W-1:0]      din,
    input  logic              pop,
    output logic [W-1:0]      dout,
    output praru_pkg::qstat_t stat
);
    import praru_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign dout       = mem_reg[rd_ptr_reg];

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- hdl/praru_back.sv -----
// ----------------------------------------------------------------------------
// praru_back
// Executes commands: round-robin search for a send, level update, queue
// drain. Holds all per-connection state and the result register.
// ----------------------------------------------------------------------------
module praru_back #(
    parameter int MAX_CONNS   = praru_pkg::MAX_CONNS_DEF,
    parameter int QUEUE_DEPTH = praru_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  praru_pkg::cfg_t   cfg,
    input  praru_pkg::cmd_t   head,
    input  praru_pkg::qstat_t qstat,
    output logic              pop,
    praru_rsp_if.source       rsp
);
    import praru_pkg::*;

    localparam int CONN_W = (MAX_CONNS > 1) ? $clog2(MAX_CONNS) : 1;
    localparam int CNT_W  = $clog2(MAX_CONNS + 1);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_SCAN
    } state_t;

    state_t              state_reg, state_next;
    logic [CONN_W-1:0]   rr_reg, rr_next;
    logic [ID_W-1:0]     next_id_reg, next_id_next;
    logic [DROP_W-1:0]   drop_reg, drop_next;
    logic [FILL_W-1:0]   fill_reg [MAX_CONNS];
    logic [FILL_W-1:0]   fill_next [MAX_CONNS];
    logic [LEVEL_W-1:0]  adm_reg [MAX_CONNS];
    logic [LEVEL_W-1:0]  adm_next [MAX_CONNS];
    logic [SENT_W-1:0]   sent_reg [MAX_CONNS];
    logic [SENT_W-1:0]   sent_next [MAX_CONNS];

    // search registers
    logic [CONN_W-1:0]   c_reg, c_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [PRIO_W-1:0]   prio_reg, prio_next;

    // result register
    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  accepted_reg, accepted_next;
    logic [CONN_IDX_W-1:0] chosen_reg, chosen_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [OUT_PRIO_W-1:0] oprio_reg, oprio_next;
    logic [DRAIN_W-1:0]    drained_reg, drained_next;
    logic [DROP_W-1:0]     dtotal_reg, dtotal_next;

    logic              emit;
    logic              emit_ok;
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  c_ext;
    logic [CNT_W-1:0]  c_inc;
    logic [CONN_W-1:0] c_adv;
    logic [CONN_W-1:0] head_idx;
    logic              hit;
    logic              last;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.accepted      = accepted_reg;
    assign rsp.chosen_conn   = chosen_reg;
    assign rsp.request_id    = id_reg;
    assign rsp.request_prio  = oprio_reg;
    assign rsp.drained_count = drained_reg;
    assign rsp.drop_total    = dtotal_reg;

    assign emit_ok = !rsp_valid_reg || rsp.ready;

    // connections in use, clamped to 1..MAX_CONNS
    always_comb
    begin
        if (cfg.num_conns == '0)
        begin
            n = CNT_W'(1);
        end
        else if (32'(cfg.num_conns) > 32'(MAX_CONNS))
        begin
            n = CNT_W'(MAX_CONNS);
        end
        else
        begin
            n = CNT_W'(cfg.num_conns);
        end
    end

    // candidate connection and its round-robin successor
    assign c_ext    = CNT_W'(c_reg);
    assign c_inc    = c_ext + 1'b1;
    assign c_adv    = (c_inc == n) ? '0 : CONN_W'(c_inc);
    assign head_idx = CONN_W'(head.conn);
    assign hit      = (fill_reg[c_reg] < FILL_W'(QUEUE_DEPTH)) &&
                      (LEVEL_W'(prio_reg) <= adm_reg[c_reg]);
    assign last     = (i_reg == n - 1'b1);

    // command sequencing
    always_comb
    begin
        state_next     = state_reg;
        rr_next        = rr_reg;
        next_id_next   = next_id_reg;
        drop_next      = drop_reg;
        fill_next      = fill_reg;
        adm_next       = adm_reg;
        sent_next      = sent_reg;
        c_next         = c_reg;
        i_next         = i_reg;
        prio_next      = prio_reg;
        pop            = 1'b0;
        emit           = 1'b0;
        accepted_next  = 1'b0;
        chosen_next    = '0;
        id_next        = '0;
        oprio_next     = '0;
        drained_next   = '0;
        dtotal_next    = drop_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    case (head.op)
                        OP_SEND:
                        begin
                            pop        = 1'b1;
                            prio_next  = head.prio;
                            c_next     = rr_reg;
                            i_next     = '0;
                            state_next = ST_NORM;
                        end
                        OP_UPDATE:
                        begin
                            if (emit_ok)
                            begin
                                pop         = 1'b1;
                                emit        = 1'b1;
                                chosen_next = head.conn;
                                if (head.conn_ok)
                                begin
                                    adm_next[head_idx] = head.level;
                                end
                            end
                        end
                        OP_DRAIN:
                        begin
                            if (emit_ok)
                            begin
                                pop         = 1'b1;
                                emit        = 1'b1;
                                chosen_next = head.conn;
                                if (head.conn_ok)
                                begin
                                    drained_next        = DRAIN_W'(fill_reg[head_idx]);
                                    sent_next[head_idx] = sent_reg[head_idx] +
                                                          SENT_W'(fill_reg[head_idx]);
                                    fill_next[head_idx] = '0;
                                end
                            end
                        end
                        default:
                        begin
                            if (emit_ok)
                            begin
                                pop  = 1'b1;
                                emit = 1'b1;
                            end
                        end
                    endcase
                end
            end

            // bring a stale pointer into range, one subtraction a cycle
            ST_NORM:
            begin
                if (c_ext >= n)
                begin
                    c_next = CONN_W'(c_ext - n);
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            // one connection checked per cycle; the check that ends the search waits while rsp is stalled
            ST_SCAN:
            begin
                if (hit || last)
                begin
                    if (emit_ok)
                    begin
                        emit       = 1'b1;
                        oprio_next = OUT_PRIO_W'(prio_reg);
                        state_next = ST_IDLE;
                        if (hit)
                        begin
                            rr_next          = c_adv;
                            fill_next[c_reg] = fill_reg[c_reg] + 1'b1;
                            accepted_next    = 1'b1;
                            chosen_next      = CONN_IDX_W'(c_reg);
                            id_next          = next_id_reg;
                            next_id_next     = next_id_reg + 1'b1;
                        end
                        else if (drop_reg != '1)
                        begin
                            drop_next   = drop_reg + 1'b1;
                            dtotal_next = drop_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    c_next = c_adv;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a write of the initial level reloads every connection
        if (cfg.load_prio)
        begin
            for (int k = 0; k < MAX_CONNS; k++)
            begin
                adm_next[k] = LEVEL_W'(cfg.load_level);
            end
        end

        rsp_valid_next = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);
    end

    // state, search registers and result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rr_reg        <= '0;
            next_id_reg   <= ID_RESET;
            drop_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            c_reg         <= '0;
            i_reg         <= '0;
            prio_reg      <= '0;
            accepted_reg  <= 1'b0;
            chosen_reg    <= '0;
            id_reg        <= '0;
            oprio_reg     <= '0;
            drained_reg   <= '0;
            dtotal_reg    <= '0;
            for (int k = 0; k < MAX_CONNS; k++)
            begin
                fill_reg[k] <= '0;
                adm_reg[k]  <= LEVEL_RESET;
                sent_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rr_reg        <= rr_next;
            next_id_reg   <= next_id_next;
            drop_reg      <= drop_next;
            rsp_valid_reg <= rsp_valid_next;
            fill_reg      <= fill_next;
            adm_reg       <= adm_next;
            sent_reg      <= sent_next;
            c_reg         <= c_next;
            i_reg         <= i_next;
            prio_reg      <= prio_next;
            if (emit)
            begin
                accepted_reg <= accepted_next;
                chosen_reg   <= chosen_next;
                id_reg       <= id_next;
                oprio_reg    <= oprio_next;
                drained_reg  <= drained_next;
                dtotal_reg   <= dtotal_next;
            end
        end
    end

endmodule

// ----- hdl/priority_admission_round_robin_unit.sv -----
// ----------------------------------------------------------------------------
// priority_admission_round_robin_unit
// Admission control over several connections: priority-gated round-robin
// placement of send requests, level updates and queue drains.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  req      in   valid/ready      req_type, hash, conn_index, new_prio
//  rsp      out  valid/ready      accepted, chosen_conn, request_id,
//                                 request_prio, drained_count, drop_total
//  cfg      in   cfg_we           cfg_index, cfg_data (no read-back)
//
//  A send passes the front holding stage, the command queue and a pointer
//  check, then the back-end search checks one of the n connections in use
//  per cycle, stopping only to wait on a stalled rsp. A pointer left stale
//  by a smaller connection count is brought into range by one subtraction
//  of n per cycle. Reset clears the queues and counters (request ids start
//  at 1) and loads level 127 into every connection. A stalled rsp holds
//  the back end; the front and the 2-entry queue take requests until full.
// ----------------------------------------------------------------------------
module priority_admission_round_robin_unit #(
    parameter int MAX_CONNS   = praru_pkg::MAX_CONNS_DEF,
    parameter int QUEUE_DEPTH = praru_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    praru_req_if.sink                        req,
    praru_rsp_if.source                      rsp,
    input  logic                             cfg_we,
    input  logic [praru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [praru_pkg::CFG_DATA_W-1:0] cfg_data
);
    import praru_pkg::*;

    localparam int CMD_W = $bits(cmd_t);

    logic [NUM_CONNS_W-1:0] num_conns_reg;
    cfg_t                   cfg;
    cmd_t                   f_cmd;
    cmd_t                   head;
    logic [CMD_W-1:0]       q_dout;
    logic                   q_push;
    logic                   q_pop;
    qstat_t                 q_stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_conns_reg <= NUM_CONNS_RESET;
        end
        else if (cfg_we && (cfg_index == CFG_NUM_CONNS))
        begin
            num_conns_reg <= NUM_CONNS_W'(cfg_data);
        end
    end

    assign cfg.num_conns  = num_conns_reg;
    assign cfg.load_prio  = cfg_we && (cfg_index == CFG_INITIAL_PRIO);
    assign cfg.load_level = INIT_PRIO_W'(cfg_data);

    assign head = cmd_t'(q_dout);

    praru_front #(
        .MAX_CONNS (MAX_CONNS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (f_cmd),
        .push  (q_push),
        .qstat (q_stat)
    );

    praru_fifo #(
        .W     (CMD_W),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (f_cmd),
        .pop   (q_pop),
        .dout  (q_dout),
        .stat  (q_stat)
    );

    praru_back #(
        .MAX_CONNS   (MAX_CONNS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .head  (head),
        .qstat (q_stat),
        .pop   (q_pop),
        .rsp   (rsp)
    );

`ifndef SYNTH
    // back end only dequeues a present command
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command dequeued from empty queue");

    // an admitted send never reports a drain
    a_accept_no_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.accepted) |-> (rsp.drained_count == '0))
        else $error("accepted send carries drained count");

    // a drain never releases more than a queue holds
    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (32'(rsp.drained_count) <= 32'(QUEUE_DEPTH)))
        else $error("drained count above queue depth");
`endif

endmodule
